// File: design/saem_pkg.sv
package saem_pkg;

    localparam int DEF_MAX_TOKENS = 1024;
    localparam int DEF_ALPHABET   = 256;
    localparam int SYM_W          = 8;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_EXTEND = 2'd1,
        CMD_BEGIN  = 2'd2,
        CMD_STEP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SYM  = 2'd2
    } t_status;

    // micro-operations issued by the controller to the datapath
    typedef enum logic [4:0] {
        DP_NOP           = 5'd0,
        DP_LOAD          = 5'd1,
        DP_INIT          = 5'd2,
        DP_ZERO          = 5'd3,
        DP_BEGINQ        = 5'd4,
        DP_STAT_SYM      = 5'd5,
        DP_STAT_FULL     = 5'd6,
        DP_EXT_START     = 5'd7,
        DP_RD_EP         = 5'd8,
        DP_WALK1         = 5'd9,
        DP_SET_Q         = 5'd10,
        DP_LINK_CUR_Q    = 5'd11,
        DP_LINK_CUR_ROOT = 5'd12,
        DP_CLONE         = 5'd13,
        DP_LINKC         = 5'd14,
        DP_CP_RD         = 5'd15,
        DP_CP_WR         = 5'd16,
        DP_WALK2         = 5'd17,
        DP_LINK_Q_C      = 5'd18,
        DP_LINK_CUR_C    = 5'd19,
        DP_RD_EM         = 5'd20,
        DP_QRESET        = 5'd21,
        DP_QADV          = 5'd22,
        DP_QBACK         = 5'd23,
        DP_QLEN          = 5'd24,
        DP_QBEST         = 5'd25,
        DP_OUT           = 5'd26
    } t_dp_op;

    typedef struct packed {
        t_cmd cmd;
        logic sym_bad;
        logic full;
        logic e_zero;
        logic e_is_q;
        logic p_none;
        logic len_fit;
        logic m_zero;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/saem_ram.sv
module saem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/saem_dp.sv
module saem_dp import saem_pkg::*; #(
    parameter int MAX_TOKENS = DEF_MAX_TOKENS,
    parameter int ALPHABET   = DEF_ALPHABET,
    localparam int NODE_CAP  = 2 * MAX_TOKENS,
    localparam int NW        = $clog2(NODE_CAP),
    localparam int CW        = $clog2(NODE_CAP + 1),
    localparam int LW        = $clog2(MAX_TOKENS + 1),
    localparam int SW        = $clog2(ALPHABET),
    localparam int EAW       = NW + SW,
    localparam int EDEPTH    = NODE_CAP * (2 ** SW)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_op           i_op,
    output t_dp_stat         o_stat,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [LW-1:0]    o_best_length,
    output logic [LW-1:0]    o_match_length,
    output logic [CW-1:0]    o_node_total,
    output logic [STATUS_W-1:0] o_status
);

    t_cmd          r_cmd;
    logic [SYM_W-1:0] r_sym;
    t_status       r_status;
    logic [CW-1:0] r_count;
    logic [NW-1:0] r_last, r_cur, r_p, r_q, r_c, r_m, r_row;
    logic [LW-1:0] r_last_len, r_lenp, r_mlen, r_best;
    logic          r_p_none;
    logic [SW-1:0] r_idx;
    logic          r_out_valid;
    logic [LW-1:0] r_o_best, r_o_mlen;
    logic [CW-1:0] r_o_count;
    t_status       r_o_status;

    logic           e_we;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [NW-1:0]  e_wdata, e_rdata;
    logic           len_we;
    logic [NW-1:0]  len_waddr, len_raddr;
    logic [LW-1:0]  len_wdata, len_rdata;
    logic           link_we;
    logic [NW-1:0]  link_waddr, link_raddr;
    logic [NW:0]    link_wdata, link_rdata;

    logic [SW-1:0]  w_srow;
    logic [NW-1:0]  w_back;

    assign w_srow = SW'(r_sym);
    // link MSB marks "no link"; falling back past the root lands on the root
    assign w_back = link_rdata[NW] ? '0 : link_rdata[NW-1:0];

    always_comb begin
        e_we       = 1'b0;
        e_waddr    = '0;
        e_wdata    = '0;
        e_raddr    = '0;
        len_we     = 1'b0;
        len_waddr  = '0;
        len_wdata  = '0;
        len_raddr  = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        case (i_op)
            DP_INIT: begin
                len_we     = 1'b1;
                link_we    = 1'b1;
                link_wdata = {1'b1, {NW{1'b0}}};
            end
            DP_ZERO: begin
                e_we    = 1'b1;
                e_waddr = {r_row, r_idx};
            end
            DP_EXT_START: begin
                len_we    = 1'b1;
                len_waddr = NW'(r_count);
                len_wdata = r_last_len + LW'(1);
            end
            DP_RD_EP: begin
                e_raddr    = {r_p, w_srow};
                link_raddr = r_p;
                len_raddr  = r_p;
            end
            DP_WALK1: begin
                e_we    = 1'b1;
                e_waddr = {r_p, w_srow};
                e_wdata = r_cur;
            end
            DP_SET_Q: begin
                len_raddr = e_rdata;
            end
            DP_LINK_CUR_Q: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                link_wdata = {1'b0, r_q};
            end
            DP_LINK_CUR_ROOT: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
            end
            DP_CLONE: begin
                len_we     = 1'b1;
                len_waddr  = NW'(r_count);
                len_wdata  = r_lenp + LW'(1);
                link_raddr = r_q;
            end
            DP_LINKC: begin
                link_we    = 1'b1;
                link_waddr = r_c;
                link_wdata = link_rdata;
            end
            DP_CP_RD: begin
                e_raddr = {r_q, r_idx};
            end
            DP_CP_WR: begin
                e_we    = 1'b1;
                e_waddr = {r_c, r_idx};
                e_wdata = e_rdata;
            end
            DP_WALK2: begin
                e_we    = 1'b1;
                e_waddr = {r_p, w_srow};
                e_wdata = r_c;
            end
            DP_LINK_Q_C: begin
                link_we    = 1'b1;
                link_waddr = r_q;
                link_wdata = {1'b0, r_c};
            end
            DP_LINK_CUR_C: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                link_wdata = {1'b0, r_c};
            end
            DP_RD_EM: begin
                e_raddr    = {r_m, w_srow};
                link_raddr = r_m;
            end
            DP_QBACK: begin
                len_raddr = w_back;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_cmd    <= t_cmd'(i_cmd);
                r_sym    <= i_symbol;
                r_status <= ST_OK;
            end
            DP_INIT: begin
                r_count    <= CW'(1);
                r_last     <= '0;
                r_last_len <= '0;
                r_m        <= '0;
                r_mlen     <= '0;
                r_best     <= '0;
                r_row      <= '0;
                r_idx      <= '0;
            end
            DP_ZERO:  r_idx <= r_idx + SW'(1);
            DP_CP_WR: r_idx <= r_idx + SW'(1);
            DP_BEGINQ: begin
                r_m    <= '0;
                r_mlen <= '0;
                r_best <= '0;
            end
            DP_STAT_SYM:  r_status <= ST_SYM;
            DP_STAT_FULL: r_status <= ST_FULL;
            DP_EXT_START: begin
                r_cur      <= NW'(r_count);
                r_p        <= r_last;
                r_p_none   <= 1'b0;
                r_last     <= NW'(r_count);
                r_last_len <= r_last_len + LW'(1);
                r_count    <= r_count + CW'(1);
                r_row      <= NW'(r_count);
                r_idx      <= '0;
            end
            DP_WALK1, DP_WALK2: begin
                r_p      <= link_rdata[NW-1:0];
                r_p_none <= link_rdata[NW];
            end
            DP_SET_Q: begin
                r_q    <= e_rdata;
                r_lenp <= len_rdata;
            end
            DP_CLONE: begin
                r_c     <= NW'(r_count);
                r_count <= r_count + CW'(1);
                r_idx   <= '0;
            end
            DP_QRESET: begin
                r_m    <= '0;
                r_mlen <= '0;
            end
            DP_QADV: begin
                r_m    <= e_rdata;
                r_mlen <= r_mlen + LW'(1);
            end
            DP_QBACK: r_m    <= w_back;
            DP_QLEN:  r_mlen <= len_rdata;
            DP_QBEST: begin
                if (r_mlen > r_best) begin
                    r_best <= r_mlen;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == DP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_OUT) begin
            r_o_best   <= r_best;
            r_o_mlen   <= r_mlen;
            r_o_count  <= r_count;
            r_o_status <= r_status;
        end
    end

    saem_ram #(.WIDTH(NW), .DEPTH(EDEPTH)) u_edge (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    saem_ram #(.WIDTH(LW), .DEPTH(NODE_CAP)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    saem_ram #(.WIDTH(NW + 1), .DEPTH(NODE_CAP)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.sym_bad  = (r_sym == '0) || (32'(r_sym) >= 32'(ALPHABET));
        o_stat.full     = ((LW + 1)'(r_last_len) >= (LW + 1)'(MAX_TOKENS)) ||
                          ((CW + 1)'(r_count) + (CW + 1)'(2) > (CW + 1)'(NODE_CAP));
        o_stat.e_zero   = (e_rdata == '0);
        o_stat.e_is_q   = (e_rdata == r_q);
        o_stat.p_none   = r_p_none;
        o_stat.len_fit  = ((LW + 1)'(r_lenp) + (LW + 1)'(1) == (LW + 1)'(len_rdata));
        o_stat.m_zero   = (r_m == '0);
        o_stat.idx_last = (r_idx == SW'(ALPHABET - 1));
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_best_length  = r_o_best;
    assign o_match_length = r_o_mlen;
    assign o_node_total   = r_o_count;
    assign o_status       = r_o_status;

endmodule

// File: design/saem_ctrl.sv
module saem_ctrl import saem_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_BOOT      = 20'h00002,
        S_BOOT_ZERO = 20'h00004,
        S_DECODE    = 20'h00008,
        S_CLR_ZERO  = 20'h00010,
        S_E_ZERO    = 20'h00020,
        S_W1_TEST   = 20'h00040,
        S_W1_CHK    = 20'h00080,
        S_E_CMP     = 20'h00100,
        S_LINKC     = 20'h00200,
        S_CP_RD     = 20'h00400,
        S_CP_WR     = 20'h00800,
        S_W2_TEST   = 20'h01000,
        S_W2_CHK    = 20'h02000,
        S_LCC       = 20'h04000,
        S_Q_RD      = 20'h08000,
        S_Q_CHK     = 20'h10000,
        S_Q_LEN     = 20'h20000,
        S_Q_BEST    = 20'h40000,
        S_FIN       = 20'h80000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_BOOT: begin
                o_op    = DP_INIT;
                n_state = S_BOOT_ZERO;
            end
            S_BOOT_ZERO: begin
                o_op = DP_ZERO;
                if (i_stat.idx_last) n_state = S_IDLE;
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_op    = DP_INIT;
                        n_state = S_CLR_ZERO;
                    end
                    CMD_EXTEND: begin
                        if (i_stat.sym_bad) begin
                            o_op    = DP_STAT_SYM;
                            n_state = S_FIN;
                        end else if (i_stat.full) begin
                            o_op    = DP_STAT_FULL;
                            n_state = S_FIN;
                        end else begin
                            o_op    = DP_EXT_START;
                            n_state = S_E_ZERO;
                        end
                    end
                    CMD_BEGIN: begin
                        o_op    = DP_BEGINQ;
                        n_state = S_FIN;
                    end
                    default: begin
                        if (i_stat.sym_bad) begin
                            o_op    = DP_QRESET;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_Q_RD;
                        end
                    end
                endcase
            end
            S_CLR_ZERO: begin
                o_op = DP_ZERO;
                if (i_stat.idx_last) n_state = S_FIN;
            end
            S_E_ZERO: begin
                o_op = DP_ZERO;
                if (i_stat.idx_last) n_state = S_W1_TEST;
            end
            S_W1_TEST: begin
                if (i_stat.p_none) begin
                    o_op    = DP_LINK_CUR_ROOT;
                    n_state = S_FIN;
                end else begin
                    o_op    = DP_RD_EP;
                    n_state = S_W1_CHK;
                end
            end
            S_W1_CHK: begin
                if (i_stat.e_zero) begin
                    o_op    = DP_WALK1;
                    n_state = S_W1_TEST;
                end else begin
                    o_op    = DP_SET_Q;
                    n_state = S_E_CMP;
                end
            end
            S_E_CMP: begin
                if (i_stat.len_fit) begin
                    o_op    = DP_LINK_CUR_Q;
                    n_state = S_FIN;
                end else begin
                    o_op    = DP_CLONE;
                    n_state = S_LINKC;
                end
            end
            S_LINKC: begin
                o_op    = DP_LINKC;
                n_state = S_CP_RD;
            end
            S_CP_RD: begin
                o_op    = DP_CP_RD;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                o_op    = DP_CP_WR;
                n_state = i_stat.idx_last ? S_W2_TEST : S_CP_RD;
            end
            S_W2_TEST: begin
                if (i_stat.p_none) begin
                    o_op    = DP_LINK_Q_C;
                    n_state = S_LCC;
                end else begin
                    o_op    = DP_RD_EP;
                    n_state = S_W2_CHK;
                end
            end
            S_W2_CHK: begin
                if (i_stat.e_is_q) begin
                    o_op    = DP_WALK2;
                    n_state = S_W2_TEST;
                end else begin
                    o_op    = DP_LINK_Q_C;
                    n_state = S_LCC;
                end
            end
            S_LCC: begin
                o_op    = DP_LINK_CUR_C;
                n_state = S_FIN;
            end
            S_Q_RD: begin
                o_op    = DP_RD_EM;
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (!i_stat.e_zero) begin
                    o_op    = DP_QADV;
                    n_state = S_Q_BEST;
                end else if (i_stat.m_zero) begin
                    o_op    = DP_QRESET;
                    n_state = S_Q_BEST;
                end else begin
                    o_op    = DP_QBACK;
                    n_state = S_Q_LEN;
                end
            end
            S_Q_LEN: begin
                o_op    = DP_QLEN;
                n_state = S_Q_RD;
            end
            S_Q_BEST: begin
                o_op    = DP_QBEST;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = DP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_BOOT;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: design/suffix_automaton_match_engine_unit.sv
// One transaction at a time; the input stalls until the result has been issued.
//   clear zeroes the root edge row; begin query and the refusals only update registers.
//   query step reads an edge, falling back along a suffix link per miss. extend zeroes the
//   new edge row, then walks suffix links adding edges until an existing edge or the root; a
//   clone copies q's row (through the single edge RAM port), then redirects edges.
// Reset: synchronous active low; afterward the root edge row is cleared, stalled.
module suffix_automaton_match_engine_unit import saem_pkg::*; #(
    parameter int MAX_TOKENS = DEF_MAX_TOKENS,
    parameter int ALPHABET   = DEF_ALPHABET,
    localparam int NODE_CAP  = 2 * MAX_TOKENS,
    localparam int CW        = $clog2(NODE_CAP + 1),
    localparam int LW        = $clog2(MAX_TOKENS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SYM_W-1:0]    i_symbol,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LW-1:0]       o_best_length,
    output logic [LW-1:0]       o_match_length,
    output logic [CW-1:0]       o_node_total,
    output logic [STATUS_W-1:0] o_status
);

    t_dp_op   op;
    t_dp_stat stat;

    saem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_stat  (stat),
        .o_op    (op)
    );

    saem_dp #(.MAX_TOKENS(MAX_TOKENS), .ALPHABET(ALPHABET)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cmd          (i_cmd),
        .i_symbol       (i_symbol),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_best_length  (o_best_length),
        .o_match_length (o_match_length),
        .o_node_total   (o_node_total),
        .o_status       (o_status)
    );

endmodule

// File: design/saem_chk.sv
module saem_chk import saem_pkg::*; #(
    parameter int MAX_TOKENS = DEF_MAX_TOKENS,
    localparam int NODE_CAP  = 2 * MAX_TOKENS,
    localparam int CW        = $clog2(NODE_CAP + 1),
    localparam int LW        = $clog2(MAX_TOKENS + 1)
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [LW-1:0]       o_best_length,
    input logic [LW-1:0]       o_match_length,
    input logic [CW-1:0]       o_node_total,
    input logic [STATUS_W-1:0] o_status
);

    a_best_ge_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_best_length >= o_match_length)
        else $error("best length below current match length");

    a_nodes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_node_total != '0)
        else $error("node count zero");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_SYM))
        else $error("undefined status code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_best_length)
            && $stable(o_node_total) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind suffix_automaton_match_engine_unit saem_chk #(.MAX_TOKENS(MAX_TOKENS)) u_saem_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_best_length  (o_best_length),
    .o_match_length (o_match_length),
    .o_node_total   (o_node_total),
    .o_status       (o_status)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import saem_pkg::*;

    localparam int MAXTOK = DEF_MAX_TOKENS;
    localparam int ALPH   = DEF_ALPHABET;
    localparam int NCAP   = 2 * MAXTOK;
    localparam int NOLINK = -1;
    localparam int LIMIT  = 20_000_000;

    typedef struct {
        logic [10:0]   best;
        logic [10:0]   cur;
        logic [11:0]   nodes;
        logic [1:0]    stat;
    } t_match_res;

    typedef struct {
        t_cmd          cmd;
        logic [7:0]    sym;
        bit            typed;
        t_match_res    res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [CMD_W-1:0] i_cmd = '0;
    logic [SYM_W-1:0] i_symbol = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [10:0] o_best_length;
    logic [10:0] o_match_length;
    logic [11:0] o_node_total;
    logic [STATUS_W-1:0] o_status;

    suffix_automaton_match_engine_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // automaton mirror
    int sa_len[NCAP];
    int sa_link[NCAP];
    int sa_edge[NCAP*ALPH];
    int sa_count, sa_last, m_node, m_len, m_best;

    t_match_res pending_q[$];
    int errors = 0;
    int accepted = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    longint cycles = 0;

    function automatic void sa_clear();
        sa_count = 1;
        sa_last = 0;
        sa_len[0] = 0;
        sa_link[0] = NOLINK;
        for (int s = 0; s < ALPH; s++) sa_edge[s] = 0;
    endfunction

    function automatic void sa_extend(int s);
        int cur, p, q, c;
        cur = sa_count++;
        p = sa_last;
        sa_len[cur] = sa_len[sa_last] + 1;
        for (int k = 0; k < ALPH; k++) sa_edge[cur*ALPH+k] = 0;
        while (p != NOLINK && sa_edge[p*ALPH+s] == 0) begin
            sa_edge[p*ALPH+s] = cur;
            p = sa_link[p];
        end
        if (p == NOLINK) begin
            sa_link[cur] = 0;
        end else begin
            q = sa_edge[p*ALPH+s];
            if (sa_len[p] + 1 == sa_len[q]) begin
                sa_link[cur] = q;
            end else begin
                // split q: clone takes q's edges and link
                c = sa_count++;
                for (int k = 0; k < ALPH; k++) sa_edge[c*ALPH+k] = sa_edge[q*ALPH+k];
                sa_len[c] = sa_len[p] + 1;
                sa_link[c] = sa_link[q];
                while (p != NOLINK && sa_edge[p*ALPH+s] == q) begin
                    sa_edge[p*ALPH+s] = c;
                    p = sa_link[p];
                end
                sa_link[q] = c;
                sa_link[cur] = c;
            end
        end
        sa_last = cur;
    endfunction

    function automatic void match_advance(int s);
        int e;
        if (s == 0) begin
            m_node = 0;
            m_len = 0;
            return;
        end
        while (m_node != 0 && sa_edge[m_node*ALPH+s] == 0) begin
            m_node = sa_link[m_node];
            if (m_node < 0) m_node = 0;
            m_len = sa_len[m_node];
        end
        e = sa_edge[m_node*ALPH+s];
        if (e != 0) begin
            m_node = e;
            m_len++;
        end else begin
            m_node = 0;
            m_len = 0;
        end
        if (m_len > m_best) m_best = m_len;
    endfunction

    function automatic t_match_res match_predict(t_cmd cmd, int s);
        t_match_res r;
        t_status st;
        st = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                sa_clear();
                m_node = 0; m_len = 0; m_best = 0;
            end
            CMD_EXTEND: begin
                if (s == 0) st = ST_SYM;
                else if (sa_len[sa_last] >= MAXTOK || sa_count + 2 > NCAP) st = ST_FULL;
                else sa_extend(s);
            end
            CMD_BEGIN: begin
                m_node = 0; m_len = 0; m_best = 0;
            end
            default: match_advance(s);
        endcase
        r.best = 11'(m_best);
        r.cur = 11'(m_len);
        r.nodes = 12'(sa_count);
        r.stat = st;
        return r;
    endfunction

    function automatic logic [7:0] pick_sym();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(1, 3));
        if (r < 90) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send(t_cmd cmd, logic [7:0] sym, bit typed, t_match_res tres);
        t_match_res p;
        if (!quiet && $urandom_range(0, 99) < 33) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_symbol <= sym;
        do @(posedge i_clk); while (o_in_stall);
        p = match_predict(cmd, sym);
        pending_q.push_back(typed ? tres : p);
        accepted++;
    endtask

    task automatic pause_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_row mk(t_cmd c, logic [7:0] s);
        t_row r;
        r.cmd = c; r.sym = s; r.typed = 1'b0; r.res = '{0, 0, 0, 0};
        return r;
    endfunction

    function automatic t_row mkx(t_cmd c, logic [7:0] s, int b, int m, int n, t_status st);
        t_row r;
        r.cmd = c; r.sym = s; r.typed = 1'b1; r.res = '{11'(b), 11'(m), 12'(n), st};
        return r;
    endfunction

    t_row dir_rows[$];

    // output stall driver; one long hold-off when requested
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 400;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        t_match_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result best=%0d match=%0d nodes=%0d status=%0d",
                         $time, o_best_length, o_match_length, o_node_total, o_status);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_best_length !== e.best || o_match_length !== e.cur ||
                    o_node_total !== e.nodes || o_status !== e.stat) begin
                    $display("%0t: mismatch exp best=%0d match=%0d nodes=%0d status=%0d",
                             $time, e.best, e.cur, e.nodes, e.stat);
                    $display("%0t:          got best=%0d match=%0d nodes=%0d status=%0d",
                             $time, o_best_length, o_match_length, o_node_total, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_row r;
        t_cmd c;
        int x;
        for (int k = 0; k < NCAP; k++) begin
            sa_len[k] = 0;
            sa_link[k] = 0;
        end
        sa_clear();
        m_node = 0; m_len = 0; m_best = 0;

        // directed: refusals, extremes, a clone, a fallback, unknown tokens
        dir_rows = '{
            mkx(CMD_BEGIN, 8'd0, 0, 0, 1, ST_OK),
            mkx(CMD_STEP, 8'd5, 0, 0, 1, ST_OK),
            mkx(CMD_EXTEND, 8'd0, 0, 0, 1, ST_SYM),
            mkx(CMD_EXTEND, 8'd255, 0, 0, 2, ST_OK),
            mk(CMD_EXTEND, 8'd1),
            mk(CMD_EXTEND, 8'd255),
            mk(CMD_EXTEND, 8'd255),
            mk(CMD_EXTEND, 8'd1),
            mk(CMD_EXTEND, 8'd170),
            mk(CMD_EXTEND, 8'd85),
            mk(CMD_BEGIN, 8'd255),
            mk(CMD_STEP, 8'd255),
            mk(CMD_STEP, 8'd255),
            mk(CMD_STEP, 8'd1),
            mk(CMD_STEP, 8'd255),
            mk(CMD_STEP, 8'd0),
            mk(CMD_STEP, 8'd1),
            mk(CMD_STEP, 8'd170),
            mk(CMD_STEP, 8'd85),
            mk(CMD_EXTEND, 8'd0),
            mkx(CMD_CLEAR, 8'd0, 0, 0, 1, ST_OK),
            mkx(CMD_STEP, 8'd255, 0, 0, 1, ST_OK),
            mk(CMD_EXTEND, 8'd2),
            mk(CMD_STEP, 8'd2)
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            send(r.cmd, r.sym, r.typed, r.res);
        end
        pause_drain();

        // mixed traffic with clears and noise
        for (int k = 0; k < 70; k++) begin
            x = $urandom_range(0, 99);
            c = x < 4 ? CMD_CLEAR : x < 55 ? CMD_EXTEND : x < 62 ? CMD_BEGIN : CMD_STEP;
            if (k == 35) pause_drain();
            send(c, pick_sym(), 1'b0, '{0, 0, 0, 0});
        end
        pause_drain();

        // build up to capacity, querying along the way, then hit the full refusal
        send(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '{0, 0, 0, 0});
        while (sa_len[sa_last] < MAXTOK) begin
            if (accepted == 400) quiet = 1'b1;
            if (accepted == 520) quiet = 1'b0;
            if (accepted == 700) hold_req = 1'b1;
            x = $urandom_range(0, 99);
            c = x < 94 ? CMD_EXTEND : x < 95 ? CMD_BEGIN : CMD_STEP;
            send(c, pick_sym(), 1'b0, '{0, 0, 0, 0});
        end
        for (int k = 0; k < 40; k++) begin
            c = $urandom_range(0, 2) == 0 ? CMD_STEP : CMD_EXTEND;
            send(c, pick_sym(), 1'b0, '{0, 0, 0, 0});
        end

        pause_drain();
        repeat (1000) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

// File: files.f
design/saem_pkg.sv
design/saem_ram.sv
design/saem_dp.sv
design/saem_ctrl.sv
design/suffix_automaton_match_engine_unit.sv
design/saem_chk.sv
sim/tb_top.sv
